@@ rtl/core/dsos_pkg.sv @@
// ----------------------------------------------------------------------------
// dsos_pkg
// Shared types and constants of the depth sector obstacle summary block.
// ----------------------------------------------------------------------------
package dsos_pkg;

    localparam int DEPTH_W = 16;
    localparam int CNT_W   = 21;
    localparam int SUM_W   = 36;
    localparam int ANG_W   = 16;
    localparam int FW_W    = 11;
    localparam int CFG_IDX_W = 2;
    localparam int CORDIC_MAX = 24;
    localparam int CZ_W    = 24;
    localparam int MAX_HEIGHT = 1024;

    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_DEPTH   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_AREA    = 2'd2;

    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};
    localparam logic signed [SUM_W-1:0] SUM_MAX = 36'sd34359738367;
    localparam logic signed [ANG_W-1:0] ANG_LIM = 16'sd23040;

    typedef struct packed {
        logic clear;
        logic pix_start;
        logic pix_step;
        logic pix_done;
        logic div_start;
        logic div_step;
        logic [1:0] sel;
        logic emit;
    } t_cmd;

    typedef struct packed {
        logic pix_last;
        logic div_last;
    } t_sts;

    function automatic logic [CZ_W-1:0] atan_q16(input logic [4:0] i);
        logic [CZ_W-1:0] v;
        unique case (i)
            5'd0: v = 24'd2949120;  5'd1: v = 24'd1740967;
            5'd2: v = 24'd919879;   5'd3: v = 24'd466945;
            5'd4: v = 24'd234379;   5'd5: v = 24'd117304;
            5'd6: v = 24'd58666;    5'd7: v = 24'd29335;
            5'd8: v = 24'd14668;    5'd9: v = 24'd7334;
            5'd10: v = 24'd3667;    5'd11: v = 24'd1833;
            5'd12: v = 24'd917;     5'd13: v = 24'd458;
            5'd14: v = 24'd229;     5'd15: v = 24'd115;
            5'd16: v = 24'd57;      5'd17: v = 24'd29;
            5'd18: v = 24'd14;      5'd19: v = 24'd7;
            5'd20: v = 24'd4;       5'd21: v = 24'd2;
            5'd22: v = 24'd1;       default: v = 24'd0;
        endcase
        return v;
    endfunction

endpackage

@@ rtl/core/dsos_ctrl.sv @@
// ----------------------------------------------------------------------------
// dsos_ctrl
// Sequencer: CORDIC iterations per pixel, then one division per sector.
// ----------------------------------------------------------------------------
module dsos_ctrl
    import dsos_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_start,
    input  logic i_last_pixel,
    input  t_sts i_sts,
    output t_cmd o_cmd,
    output logic o_busy
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_PIX  = 2'd1;
    localparam logic [1:0] S_DIV  = 2'd2;
    localparam logic [1:0] S_LOAD = 2'd3;

    logic [1:0] r_state, n_state;
    logic [1:0] r_sel, n_sel;
    logic       r_last, n_last;

    always_comb begin
        n_state = r_state;
        n_sel   = r_sel;
        n_last  = r_last;
        o_cmd   = '0;
        o_cmd.sel = r_sel;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.pix_start = 1'b1;
                    n_last  = i_last_pixel;
                    n_state = S_PIX;
                end
            end
            S_PIX: begin
                o_cmd.pix_step = 1'b1;
                if (i_sts.pix_last) begin
                    o_cmd.pix_done = 1'b1;
                    if (r_last) begin
                        n_sel   = 2'd0;
                        n_state = S_LOAD;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_LOAD: begin
                o_cmd.div_start = 1'b1;
                n_state = S_DIV;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.div_last) begin
                    o_cmd.emit = 1'b1;
                    if (r_sel == 2'd2) begin
                        o_cmd.clear = 1'b1;
                        n_state = S_IDLE;
                    end else begin
                        n_sel   = r_sel + 2'd1;
                        n_state = S_LOAD;
                    end
                end
            end
        endcase
    end

    assign o_busy = (r_state != S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_sel   <= 2'd0;
            r_last  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_sel   <= n_sel;
            r_last  <= n_last;
        end
    end

endmodule

@@ rtl/core/dsos_dp.sv @@
// ----------------------------------------------------------------------------
// dsos_dp
// Column counter, iterative CORDIC, sector accumulators, serial divider.
// ----------------------------------------------------------------------------
module dsos_dp
    import dsos_pkg::*;
#(
    parameter int MAX_WIDTH    = 1024,
    parameter int CORDIC_STEPS = 16
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_cmd                    i_cmd,
    output t_sts                    o_sts,
    input  logic [DEPTH_W-1:0]      i_depth_mm,
    input  logic                    i_cfg_we,
    input  logic [CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [31:0]             i_cfg_data,
    output logic                    o_valid,
    output logic signed [1:0]       o_sector,
    output logic                    o_active,
    output logic [DEPTH_W-1:0]      o_nearest_mm,
    output logic [CNT_W-1:0]        o_blob_area,
    output logic signed [ANG_W-1:0] o_mean_angle_q8,
    output logic                    o_last_summary
);

    localparam int COL_W  = $clog2(MAX_WIDTH);
    localparam int W_W    = $clog2(MAX_WIDTH + 1);
    localparam int STEPS  = (CORDIC_STEPS > CORDIC_MAX) ? CORDIC_MAX : CORDIC_STEPS;
    localparam int STEP_W = $clog2(STEPS + 1);
    localparam int Y0_W   = W_W + 11;
    localparam int CX_W   = Y0_W + 18;
    localparam int CZS_W  = CZ_W + 2;
    localparam int DIV_W  = SUM_W;
    localparam int DC_W   = $clog2(DIV_W + 1);
    localparam logic [W_W-1:0] MAXW = W_W'(MAX_WIDTH);

    logic [FW_W-1:0]    r_frame_width;
    logic [DEPTH_W-1:0] r_max_depth;
    logic [CNT_W-1:0]   r_min_area;
    logic [COL_W-1:0]   r_col;

    logic [DEPTH_W-1:0]     r_near [3];
    logic [CNT_W-1:0]       r_cnt  [3];
    logic signed [SUM_W-1:0] r_sum [3];

    logic [W_W-1:0] w_eff;
    logic [W_W-1:0] third;
    logic [1:0]     sec_in;
    logic           keep_in;

    always_comb begin
        if (r_frame_width == '0) w_eff = W_W'(1);
        else if (32'(r_frame_width) > 32'(MAX_WIDTH)) w_eff = MAXW;
        else w_eff = W_W'(r_frame_width);
        third = W_W'((32'(w_eff) * 32'd43691) >> 17);
        keep_in = (i_depth_mm != '0) && (i_depth_mm <= r_max_depth);
        if (W_W'(r_col) < third) sec_in = 2'd0;
        else if (W_W'(r_col) >= w_eff - third) sec_in = 2'd2;
        else sec_in = 2'd1;
    end

    logic                    r_keep, r_neg;
    logic [1:0]              r_sec;
    logic [STEP_W-1:0]       r_step;
    logic signed [CX_W-1:0]  r_x, r_y;
    logic signed [CZS_W-1:0] r_z;
    logic signed [Y0_W-1:0]  y0;
    logic [Y0_W-1:0]         y0_abs;

    always_comb begin
        y0 = (Y0_W'($signed({1'b0, r_col, 1'b0})) - Y0_W'($signed({1'b0, w_eff}))
              + Y0_W'(1)) * Y0_W'(500);
        y0_abs = y0[Y0_W-1] ? Y0_W'(-y0) : y0;
    end

    logic signed [CX_W-1:0] dx, dy;
    logic [4:0] step_i;
    assign step_i = 5'(r_step);
    assign dx = r_y >>> step_i;
    assign dy = r_x >>> step_i;
    assign o_sts.pix_last = (r_step == STEP_W'(STEPS));

    logic signed [CZS_W-1:0] zr;
    logic signed [ANG_W-1:0] ang;
    always_comb begin
        zr = (r_z + CZS_W'(128)) >>> 8;
        if (zr > CZS_W'(ANG_LIM)) ang = ANG_LIM;
        else if (zr < -CZS_W'(ANG_LIM)) ang = -ANG_LIM;
        else ang = ANG_W'(zr);
        if (r_neg) ang = -ang;
    end

    logic signed [SUM_W+1:0] sum_nx;
    assign sum_nx = (SUM_W+2)'(r_sum[r_sec]) + (SUM_W+2)'(ang);

    logic [DIV_W-1:0] r_rem, r_quo;
    logic [DC_W-1:0]  r_dcnt;
    logic             r_dneg;
    logic [DIV_W:0]   trial;
    logic signed [SUM_W-1:0] ssel;
    logic             act_sel;
    assign ssel = r_sum[i_cmd.sel];
    assign act_sel = (r_cnt[i_cmd.sel] != '0) && (r_cnt[i_cmd.sel] >= r_min_area);
    assign trial = {r_rem[DIV_W-2:0], r_quo[DIV_W-1]} - {{(DIV_W-CNT_W){1'b0}}, 1'b0,
                    r_cnt[i_cmd.sel]};
    assign o_sts.div_last = (r_dcnt == DC_W'(DIV_W - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width <= FW_W'(640);
            r_max_depth   <= DEPTH_W'(1500);
            r_min_area    <= CNT_W'(1);
            r_col         <= '0;
            for (int k = 0; k < 3; k++) begin
                r_near[k] <= '1;
                r_cnt[k]  <= '0;
                r_sum[k]  <= '0;
            end
            o_valid <= 1'b0;
        end else begin
            o_valid <= i_cmd.emit;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_FRAME_WIDTH: begin
                        r_frame_width <= i_cfg_data[FW_W-1:0];
                        r_col <= '0;
                    end
                    CFG_MAX_DEPTH: r_max_depth <= i_cfg_data[DEPTH_W-1:0];
                    CFG_MIN_AREA:  r_min_area  <= i_cfg_data[CNT_W-1:0];
                    default: ;
                endcase
            end
            if (i_cmd.pix_start) begin
                r_col <= (W_W'(r_col) + W_W'(1) >= w_eff) ? '0 : r_col + COL_W'(1);
                if (keep_in && i_depth_mm < r_near[sec_in]) r_near[sec_in] <= i_depth_mm;
            end
            if (i_cmd.pix_done) begin
                if (r_keep && r_cnt[r_sec] != CNT_MAX) begin
                    r_cnt[r_sec] <= r_cnt[r_sec] + CNT_W'(1);
                    if (sum_nx > (SUM_W+2)'(SUM_MAX)) r_sum[r_sec] <= SUM_MAX;
                    else if (sum_nx < -(SUM_W+2)'(SUM_MAX)) r_sum[r_sec] <= -SUM_MAX;
                    else r_sum[r_sec] <= SUM_W'(sum_nx);
                end
            end
            if (i_cmd.clear) begin
                r_col <= '0;
                for (int k = 0; k < 3; k++) begin
                    r_near[k] <= '1;
                    r_cnt[k]  <= '0;
                    r_sum[k]  <= '0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.pix_start) begin
            r_keep <= keep_in;
            r_sec  <= sec_in;
            r_neg  <= y0[Y0_W-1];
            r_step <= '0;
            r_x    <= CX_W'({i_depth_mm, 16'd0});
            r_y    <= CX_W'({y0_abs, 16'd0});
            r_z    <= '0;
        end else if (i_cmd.pix_step) begin
            r_step <= r_step + STEP_W'(1);
            if (!r_y[CX_W-1]) begin
                r_x <= r_x + dx;
                r_y <= r_y - dy;
                r_z <= r_z + CZS_W'(atan_q16(step_i));
            end else begin
                r_x <= r_x - dx;
                r_y <= r_y + dy;
                r_z <= r_z - CZS_W'(atan_q16(step_i));
            end
        end
        if (i_cmd.div_start) begin
            r_rem  <= '0;
            r_quo  <= ssel[SUM_W-1] ? DIV_W'(-ssel) : DIV_W'(ssel);
            r_dneg <= ssel[SUM_W-1];
            r_dcnt <= '0;
        end else if (i_cmd.div_step) begin
            r_dcnt <= r_dcnt + DC_W'(1);
            if (!trial[DIV_W]) begin
                r_rem <= trial[DIV_W-1:0];
                r_quo <= {r_quo[DIV_W-2:0], 1'b1};
            end else begin
                r_rem <= {r_rem[DIV_W-2:0], r_quo[DIV_W-1]};
                r_quo <= {r_quo[DIV_W-2:0], 1'b0};
            end
        end
    end

    logic [DIV_W-1:0] q_fin;
    assign q_fin = {r_quo[DIV_W-2:0], ~trial[DIV_W]};

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            o_sector        <= $signed(i_cmd.sel - 2'd1);
            o_active        <= act_sel;
            o_nearest_mm    <= act_sel ? r_near[i_cmd.sel] : '0;
            o_blob_area     <= act_sel ? r_cnt[i_cmd.sel] : '0;
            o_mean_angle_q8 <= !act_sel ? '0 :
                               r_dneg ? ANG_W'(-q_fin) : ANG_W'(q_fin);
            o_last_summary  <= (i_cmd.sel == 2'd2);
        end
    end

endmodule

@@ rtl/core/depth_sector_obstacle_summary.sv @@
// ----------------------------------------------------------------------------
// depth_sector_obstacle_summary
// Per-sector nearest depth, area and mean angle of close pixels in a frame.
// ----------------------------------------------------------------------------
// Usage:
//   Pixel channel: drive i_depth_mm and i_last_pixel with start while
//   busy is low; the transaction is taken at that edge.
//   Each pixel holds busy after that edge: the load happens at the edge,
//   then one CORDIC iteration per cycle in a single shared rotator and an
//   accumulate step, so a new pixel is taken only once the last one is
//   through and busy is low again.
//   On the last pixel of a frame, three summaries (left, centre, right)
//   follow, each after a dividend load step and a restoring divider pass;
//   busy falls as the third appears. Each summary is on the result ports
//   for one cycle with o_valid high; the receiver cannot stall.
//   Configuration: i_cfg_valid/o_cfg_ready, index and data; writes are
//   always taken. The user must make them while the block is idle; the
//   block does not enforce it. Reset: synchronous active low; the
//   config registers take their defaults and all sector accumulators clear.
// ----------------------------------------------------------------------------
module depth_sector_obstacle_summary
    import dsos_pkg::*;
#(
    parameter int MAX_WIDTH    = 1024,
    parameter int CORDIC_STEPS = 16
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    start,
    output logic                    busy,
    input  logic [DEPTH_W-1:0]      i_depth_mm,
    input  logic                    i_last_pixel,
    input  logic                    i_cfg_valid,
    output logic                    o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [31:0]             i_cfg_data,
    output logic                    o_valid,
    output logic signed [1:0]       o_sector,
    output logic                    o_active,
    output logic [DEPTH_W-1:0]      o_nearest_mm,
    output logic [CNT_W-1:0]        o_blob_area,
    output logic signed [ANG_W-1:0] o_mean_angle_q8,
    output logic                    o_last_summary
);

    t_cmd cmd;
    t_sts sts;
    logic go;

    assign o_cfg_ready = 1'b1;
    assign go = start && !busy;

    dsos_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (go),
        .i_last_pixel (i_last_pixel),
        .i_sts        (sts),
        .o_cmd        (cmd),
        .o_busy       (busy)
    );

    dsos_dp #(
        .MAX_WIDTH    (MAX_WIDTH),
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .i_depth_mm      (i_depth_mm),
        .i_cfg_we        (i_cfg_valid),
        .i_cfg_idx       (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .o_valid         (o_valid),
        .o_sector        (o_sector),
        .o_active        (o_active),
        .o_nearest_mm    (o_nearest_mm),
        .o_blob_area     (o_blob_area),
        .o_mean_angle_q8 (o_mean_angle_q8),
        .o_last_summary  (o_last_summary)
    );

endmodule

@@ rtl/core/dsos_checker.sv @@
// ----------------------------------------------------------------------------
// dsos_checker
// Port-level checks of the summary output sequence.
// ----------------------------------------------------------------------------
module dsos_checker
    import dsos_pkg::*;
(
    input logic                    i_clk,
    input logic                    i_rst_n,
    input logic                    busy,
    input logic                    o_valid,
    input logic                    o_active,
    input logic [DEPTH_W-1:0]      o_nearest_mm,
    input logic [CNT_W-1:0]        o_blob_area,
    input logic signed [ANG_W-1:0] o_mean_angle_q8,
    input logic                    o_last_summary
);

    a_inactive_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_active |-> o_nearest_mm == '0 && o_blob_area == '0
            && o_mean_angle_q8 == '0)
        else $error("inactive summary not zero");

    a_active_area: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_active |-> o_blob_area != '0)
        else $error("active summary with zero area");

    a_angle_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_mean_angle_q8 <= ANG_LIM && o_mean_angle_q8 >= -ANG_LIM)
        else $error("mean angle out of range");

    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_last_summary |-> !busy)
        else $error("busy after last summary");

endmodule

bind depth_sector_obstacle_summary dsos_checker u_dsos_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .busy            (busy),
    .o_valid         (o_valid),
    .o_active        (o_active),
    .o_nearest_mm    (o_nearest_mm),
    .o_blob_area     (o_blob_area),
    .o_mean_angle_q8 (o_mean_angle_q8),
    .o_last_summary  (o_last_summary)
);
